>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the deque engine.
// Needs nothing else; include it with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is held.
`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion sampled on the rising clock, checked during reset too.
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> sv/cdq_pkg.sv
// Shared types and constants of the circular deque engine.
// No dependencies; the other files of the block that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  // Fixed field widths of the request and result channels.
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  // Defaults of the top-level parameters.
  localparam int DEF_CAPACITY     = 16;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_PAYLOAD_BITS = 32;

  // Operation codes carried in a request.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5,
    KIND_FIND_KEY   = 3'd6,
    KIND_FIND_POS   = 3'd7
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_NOKEY  = 3'd3,
    STAT_RANGE  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // a request is taken this cycle
    logic scan;   // one key comparison step of a search
    logic load;   // the result moves into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // the offered request is a search over a non-empty deque
    logic hit;        // the entry under comparison matches the search key
    logic last;       // the entry under comparison is the rear entry
    logic out_free;   // the output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

>>> sv/cdq_if.sv
// Valid/ready channel interfaces for requests and results of the deque engine.
// Depends on cdq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation with its operands.
interface cdq_in_if;
  logic                         valid;
  logic                         ready;
  logic [cdq_pkg::KIND_W-1:0]   kind;
  logic [cdq_pkg::KEY_W-1:0]    entry_key;
  logic [cdq_pkg::PAY_W-1:0]    entry_payload;
  logic [cdq_pkg::KEY_W-1:0]    search_key;
  logic [cdq_pkg::POS_W-1:0]    position;

  modport source (
    output valid, kind, entry_key, entry_payload, search_key, position,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_key, entry_payload, search_key, position,
    output ready
  );
endinterface

// Result channel: status, entry and occupancy of one request.
interface cdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::STATUS_W-1:0]  status;
  logic [cdq_pkg::KEY_W-1:0]     out_key;
  logic [cdq_pkg::PAY_W-1:0]     out_payload;
  logic [cdq_pkg::OCC_W-1:0]     occupancy;

  modport source (
    output valid, status, out_key, out_payload, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_key, out_payload, occupancy,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/cdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic      [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/cdq_ctrl.sv
// Controller of the deque engine: sequences request intake, key search and result load.
// Depends on cdq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cdq_pkg::sts_t sts,
  output cdq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands. Intake stays closed while reset is held, so no
  // request is shown as taken and then dropped.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.start = 1'b1;
          state_nxt = sts.need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/cdq_dp.sv
// Datapath of the deque engine: indices, count, entry memory, search compare and
// the output register. Depends on cdq_pkg and cdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module cdq_dp #(
  parameter int CAPACITY     = cdq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = cdq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = cdq_pkg::DEF_PAYLOAD_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cdq_pkg::cmd_t                  cmd,
  output cdq_pkg::sts_t                       sts,
  input  wire logic [cdq_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [cdq_pkg::KEY_W-1:0]      in_entry_key,
  input  wire logic [cdq_pkg::PAY_W-1:0]      in_entry_payload,
  input  wire logic [cdq_pkg::KEY_W-1:0]      in_search_key,
  input  wire logic [cdq_pkg::POS_W-1:0]      in_position,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [cdq_pkg::STATUS_W-1:0]        out_status,
  output logic [cdq_pkg::KEY_W-1:0]           out_key,
  output logic [cdq_pkg::PAY_W-1:0]           out_payload,
  output logic [cdq_pkg::OCC_W-1:0]           out_occupancy
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EW    = KEY_BITS + PAYLOAD_BITS;
  localparam int CMPW  = (CW > cdq_pkg::POS_W) ? CW : cdq_pkg::POS_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
  localparam logic [IW:0]   CAP_WIDE  = (IW + 1)'(CAPACITY);

  // Circular slot stepping.
  function automatic logic [IW-1:0] slot_after(input logic [IW-1:0] i);
    slot_after = (i == LAST_SLOT) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] slot_before(input logic [IW-1:0] i);
    slot_before = (i == '0) ? LAST_SLOT : i - IW'(1);
  endfunction

  // Control state.
  logic [IW-1:0]    front_r, front_nxt;
  logic [IW-1:0]    rear_r, rear_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Per-request working registers.
  cdq_pkg::status_t status_r, status_nxt;
  logic             has_data_r, has_data_nxt;
  logic [KEY_BITS-1:0] skey_r, skey_nxt;
  logic [CW-1:0]    scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]    scan_slot_r, scan_slot_nxt;

  // Output register payload.
  logic [cdq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [cdq_pkg::KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [cdq_pkg::PAY_W-1:0]    out_payload_r, out_payload_nxt;
  logic [cdq_pkg::OCC_W-1:0]    out_occ_r, out_occ_nxt;

  // Memory port signals.
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [EW-1:0]    rd_data;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  cdq_pkg::kind_t   kind;
  logic             pos_out_of_range;
  logic [IW:0]      pos_sum;
  logic [IW-1:0]    pos_slot;

  cdq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key  = rd_data[EW-1:PAYLOAD_BITS];
  assign rd_pay  = rd_data[PAYLOAD_BITS-1:0];
  assign wr_data = {in_entry_key[KEY_BITS-1:0], in_entry_payload[PAYLOAD_BITS-1:0]};
  assign kind    = cdq_pkg::kind_t'(in_kind);

  // Logical position to slot: front plus position, wrapped once.
  assign pos_out_of_range = (CMPW'(in_position) >= CMPW'(cnt_r));
  assign pos_sum  = {1'b0, front_r} + (IW + 1)'(in_position);
  assign pos_slot = (pos_sum >= CAP_WIDE) ? IW'(pos_sum - CAP_WIDE) : pos_sum[IW-1:0];

  // Status toward the controller.
  always_comb begin
    sts.need_scan = (kind == cdq_pkg::KIND_FIND_KEY) && (cnt_r != '0);
    sts.hit       = (rd_key == skey_r);
    sts.last      = ((scan_idx_r + CW'(1)) == cnt_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Request execution and search steps.
  always_comb begin
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    has_data_nxt  = has_data_r;
    skey_nxt      = skey_r;
    scan_idx_nxt  = scan_idx_r;
    scan_slot_nxt = scan_slot_r;
    wr_en         = 1'b0;
    wr_addr       = front_r;
    rd_en         = 1'b0;
    rd_addr       = front_r;

    if (cmd.start) begin
      status_nxt   = cdq_pkg::STAT_OK;
      has_data_nxt = 1'b0;
      case (kind)
        cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
          if (cnt_r == CAP_CNT) begin
            status_nxt = cdq_pkg::STAT_FULL;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r == '0) begin
              // First entry always lands in slot zero.
              front_nxt = '0;
              rear_nxt  = '0;
              wr_addr   = '0;
            end else if (kind == cdq_pkg::KIND_PUSH_FRONT) begin
              front_nxt = slot_before(front_r);
              wr_addr   = slot_before(front_r);
            end else begin
              rear_nxt = slot_after(rear_r);
              wr_addr  = slot_after(rear_r);
            end
          end
        end
        cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK,
        cdq_pkg::KIND_PEEK_FRONT, cdq_pkg::KIND_PEEK_BACK: begin
          if (cnt_r == '0) begin
            status_nxt = cdq_pkg::STAT_EMPTY;
          end else begin
            rd_en        = 1'b1;
            has_data_nxt = 1'b1;
            if (kind == cdq_pkg::KIND_POP_FRONT || kind == cdq_pkg::KIND_PEEK_FRONT) begin
              rd_addr = front_r;
            end else begin
              rd_addr = rear_r;
            end
            if (kind == cdq_pkg::KIND_POP_FRONT || kind == cdq_pkg::KIND_POP_BACK) begin
              cnt_nxt = cnt_r - CW'(1);
              if (cnt_r == CW'(1)) begin
                // Emptied deque restarts at slot zero.
                front_nxt = '0;
                rear_nxt  = '0;
              end else if (kind == cdq_pkg::KIND_POP_FRONT) begin
                front_nxt = slot_after(front_r);
              end else begin
                rear_nxt = slot_before(rear_r);
              end
            end
          end
        end
        cdq_pkg::KIND_FIND_KEY: begin
          if (cnt_r == '0) begin
            status_nxt = cdq_pkg::STAT_NOKEY;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = front_r;
            skey_nxt      = in_search_key[KEY_BITS-1:0];
            scan_idx_nxt  = '0;
            scan_slot_nxt = front_r;
          end
        end
        cdq_pkg::KIND_FIND_POS: begin
          if (pos_out_of_range) begin
            status_nxt = cdq_pkg::STAT_RANGE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = pos_slot;
            has_data_nxt = 1'b1;
          end
        end
        default: begin
          status_nxt = cdq_pkg::STAT_OK;
        end
      endcase
    end

    // One comparison per cycle; on a miss before the rear entry the next entry is fetched.
    if (cmd.scan) begin
      if (sts.hit) begin
        has_data_nxt = 1'b1;
      end else if (sts.last) begin
        status_nxt = cdq_pkg::STAT_NOKEY;
      end else begin
        rd_en         = 1'b1;
        rd_addr       = slot_after(scan_slot_r);
        scan_slot_nxt = slot_after(scan_slot_r);
        scan_idx_nxt  = scan_idx_r + CW'(1);
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_key_nxt     = out_key_r;
    out_payload_nxt = out_payload_r;
    out_occ_nxt     = out_occ_r;
    if (cmd.load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = status_r;
      out_key_nxt     = has_data_r ? cdq_pkg::KEY_W'(rd_key) : '0;
      out_payload_nxt = has_data_r ? cdq_pkg::PAY_W'(rd_pay) : '0;
      out_occ_nxt     = cdq_pkg::OCC_W'(cnt_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      rear_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    has_data_r    <= has_data_nxt;
    skey_r        <= skey_nxt;
    scan_idx_r    <= scan_idx_nxt;
    scan_slot_r   <= scan_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_key_r     <= out_key_nxt;
    out_payload_r <= out_payload_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_payload_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

>>> sv/circular_deque_engine_core.sv
// Top level of the circular deque engine: controller plus datapath.
// Depends on cdq_pkg, cdq_if, cdq_ctrl, cdq_dp and cdq_ram.
//
// Fixed-capacity double-ended queue of key and payload entries kept in a circular
// RAM of CAPACITY words. Each request pushes, pops or peeks at either end, searches
// from the front for a key, or reads the entry at a position from the front, and
// returns one result with a status, the entry (zero when there is none) and the
// occupancy after the operation. A push into a full deque reports full and changes
// nothing. Find-by-key compares the entries one after another from the front, at
// most the occupancy of them, because the single read port of the entry RAM
// delivers one entry per cycle. One request is worked on at a time; a new request
// is taken while the previous result still waits in the output register. The
// entry RAM needs no clearing after reset, so the block is ready in the first
// cycle out of reset.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_engine_core #(
  parameter int CAPACITY     = cdq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = cdq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = cdq_pkg::DEF_PAYLOAD_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cdq_in_if.sink    in_req,
  cdq_out_if.source out_rsp
);

  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;
  logic          in_ready;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdq_dp #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_req.kind),
    .in_entry_key     (in_req.entry_key),
    .in_entry_payload (in_req.entry_payload),
    .in_search_key    (in_req.search_key),
    .in_position      (in_req.position),
    .out_ready        (out_rsp.ready),
    .out_valid        (out_rsp.valid),
    .out_status       (out_rsp.status),
    .out_key          (out_rsp.out_key),
    .out_payload      (out_rsp.out_payload),
    .out_occupancy    (out_rsp.occupancy)
  );

  assign in_req.ready = in_ready;

endmodule

`default_nettype wire

>>> sv/cdq_checker.sv
// Port-level checks of the circular deque engine, bound to its top level.
// Depends on cdq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cdq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [cdq_pkg::STATUS_W-1:0]  out_status,
  input wire logic [cdq_pkg::KEY_W-1:0]     out_key,
  input wire logic [cdq_pkg::PAY_W-1:0]     out_payload,
  input wire logic [cdq_pkg::OCC_W-1:0]     out_occupancy
);

  // No result is shown in the cycle after reset.
  `CDQ_ASSERT_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

  // Only one request is in flight: intake closes right after a request is taken.
  `CDQ_ASSERT(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second request taken while busy")

  // A failed operation returns no entry.
  `CDQ_ASSERT(a_fail_zero_entry, clk, rst_n, (out_valid && out_status != cdq_pkg::STAT_OK) |-> (out_key == '0 && out_payload == '0), "entry returned with a failure status")

  // An empty status goes with zero occupancy.
  `CDQ_ASSERT(a_empty_occupancy, clk, rst_n, (out_valid && out_status == cdq_pkg::STAT_EMPTY) |-> (out_occupancy == '0), "empty status with nonzero occupancy")

  // A stalled result holds its status, key and occupancy.
  `CDQ_ASSERT(a_stall_holds, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_key) && $stable(out_occupancy)), "stalled result changed")

endmodule

bind circular_deque_engine_core cdq_checker u_cdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_status    (out_rsp.status),
  .out_key       (out_rsp.out_key),
  .out_payload   (out_rsp.out_payload),
  .out_occupancy (out_rsp.occupancy)
);

`default_nettype wire
